### rtl/core/vmpe_pkg.sv
package vmpe_pkg;

  // Input commands
  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_COLOR = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;
  localparam logic [1:0] CMD_FONT  = 2'd3;

  // Display modes; codes above MODE_4BPP behave as 8bpp
  localparam logic [2:0] MODE_TEXT   = 3'd0;
  localparam logic [2:0] MODE_CGA    = 3'd1;
  localparam logic [2:0] MODE_LOWRES = 3'd2;
  localparam logic [2:0] MODE_4BPP   = 3'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_FG    = 2'd1;
  localparam logic [1:0] REG_ZFILL = 2'd2;

  localparam int COLOR_DEPTH = 256;
  localparam int TEXT_DEPTH  = 16;
  // Holds char * GLYPH_ROWS + line only while the sum stays below 8192
  localparam int FONT_CALC_W = 13;

  // One pixel read request from the expander
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       text;
    logic [7:0] color_idx;
    logic [3:0] text_idx;
  } pix_req_t;

  // One finished result
  typedef struct packed {
    logic [15:0] rgb;
    logic        last;
  } pix_t;

  // Index of the final pixel for a mode
  function automatic logic [2:0] last_index(input logic [2:0] mode);
    logic [2:0] r;
    case (mode)
      MODE_TEXT:   r = 3'd7;
      MODE_CGA:    r = 3'd3;
      MODE_LOWRES: r = 3'd3;
      MODE_4BPP:   r = 3'd1;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] to_rgb565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

### rtl/core/vmpe_ram.sv
module vmpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/vmpe_expander.sv
module vmpe_expander (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [2:0]          mode,
  input  logic [3:0]          fg,
  input  logic                zfill,
  input  logic                blank,
  input  logic [7:0]          src,
  input  logic [7:0]          attr,
  input  logic [7:0]          font_row,
  input  logic                grant,
  output vmpe_pkg::pix_req_t  req
);

  logic       valid;
  logic [2:0] k;
  logic [2:0] item_mode;
  logic [3:0] item_fg;
  logic       item_zfill;
  logic       item_blank;
  logic [7:0] item_src;
  logic [7:0] item_attr;

  logic [7:0] row;
  logic [1:0] cga_v;
  logic [3:0] nib;
  logic       is_last;

  // Hold the item and step through its pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      k     <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      k     <= 3'd0;
    end else if (grant && is_last) begin
      valid <= 1'b0;
    end else if (grant) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_mode  <= mode;
      item_fg    <= fg;
      item_zfill <= zfill;
      item_blank <= blank;
      item_src   <= src;
      item_attr  <= attr;
    end
  end

  assign is_last = (k == vmpe_pkg::last_index(item_mode));

  // Pick the table index of the current pixel
  always_comb begin
    row   = item_blank ? 8'd0 : font_row;
    cga_v = 2'(item_src >> {~k[1:0], 1'b0});
    nib   = 4'd0;
    req   = '0;
    req.valid = valid;
    req.last  = is_last;
    case (item_mode)
      vmpe_pkg::MODE_TEXT: begin
        req.text     = 1'b1;
        req.text_idx = row[k] ? item_attr[3:0] : item_attr[7:4];
      end
      vmpe_pkg::MODE_CGA: begin
        req.color_idx = (cga_v != 2'd0) ? {6'd0, cga_v} : {4'd0, item_fg};
      end
      vmpe_pkg::MODE_LOWRES: begin
        nib = k[1] ? item_src[3:0] : item_src[7:4];
        if (item_zfill && nib == 4'd0) begin
          nib = item_fg;
        end
        req.color_idx = {4'd0, nib};
      end
      vmpe_pkg::MODE_4BPP: begin
        nib           = k[0] ? item_src[3:0] : item_src[7:4];
        req.color_idx = {4'd0, nib};
      end
      default: begin
        req.color_idx = item_src;
      end
    endcase
  end

endmodule

### rtl/core/vmpe_out_buf.sv
module vmpe_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vmpe_pkg::pix_t  push_data,
  input  logic            pop,
  output logic            not_empty,
  output logic [1:0]      count,
  output vmpe_pkg::pix_t  head
);

  vmpe_pkg::pix_t slot [2];
  logic           wptr;
  logic           rptr;

  // Two-entry queue between the read stage and the output
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_data;
    end
  end

  assign not_empty = (count != 2'd0);
  assign head      = slot[rptr];

endmodule

### rtl/core/video_memory_pixel_expander_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    cmd, entry_index, color_rgb888,
//                                             text_color_rgb565, font_row_bits,
//                                             source_byte, attr_byte, glyph_line
// out       output     out_valid / out_ready  pixel_rgb565, last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel item yields 8 pixels in text mode, 4 in CGA and low-res, 2 in 4bpp 320
// and 1 in 8bpp: one pixel per cycle per table read, while the result queue has room.
// A table or font write is accepted once the previous item has issued all reads.
// Reset clears control state and the colour table valid bits; no clearing pass.
// Output stalls back up through a two-entry result queue into the expander.
module video_memory_pixel_expander_top #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [10:0] entry_index,
  input  logic [23:0] color_rgb888,
  input  logic [15:0] text_color_rgb565,
  input  logic [7:0]  font_row_bits,
  input  logic [7:0]  source_byte,
  input  logic [7:0]  attr_byte,
  input  logic [2:0]  glyph_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_rgb565,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int FCW        = vmpe_pkg::FONT_CALC_W;
  localparam int COLOR_BITS = vmpe_pkg::COLOR_DEPTH;

  logic [2:0] display_mode;
  logic [3:0] foreground_color;
  logic       zero_fill_lowres;

  vmpe_pkg::pix_req_t req;
  vmpe_pkg::pix_t     rd_pix;
  vmpe_pkg::pix_t     head;

  logic           in_xfer;
  logic           pix_load;
  logic           issue;
  logic           pop;
  logic [1:0]     buf_count;
  logic           rd_valid;
  logic           rd_text;
  logic           rd_cvalid;
  logic           rd_last;
  logic [COLOR_BITS-1:0] cvalid;
  logic           blank;
  logic [FCW-1:0] font_raddr;
  logic [FCW-1:0] font_widx;
  logic [15:0]    color_rdata;
  logic [15:0]    text_rdata;
  logic [7:0]     font_rdata;
  logic           color_we;
  logic           text_we;
  logic           font_we;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode     <= 3'd0;
      foreground_color <= 4'd0;
      zero_fill_lowres <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vmpe_pkg::REG_MODE:  display_mode     <= cfg_data[2:0];
        vmpe_pkg::REG_FG:    foreground_color <= cfg_data;
        vmpe_pkg::REG_ZFILL: zero_fill_lowres <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input acceptance: writes wait for the expander to drain its reads
  assign pop   = out_valid && out_ready;
  assign issue = req.valid &&
                 ({1'b0, rd_valid} + {1'b0, buf_count} <= 3'd1 + {2'b0, pop});

  always_comb begin
    if (cmd == vmpe_pkg::CMD_PIXEL) begin
      in_ready = !req.valid || (issue && req.last);
    end else begin
      in_ready = !req.valid;
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign pix_load = in_xfer && (cmd == vmpe_pkg::CMD_PIXEL);

  // Table write decode
  assign font_widx = {2'b0, entry_index};
  assign color_we  = in_xfer && (cmd == vmpe_pkg::CMD_COLOR) && (entry_index[10:8] == 3'd0);
  assign text_we   = in_xfer && (cmd == vmpe_pkg::CMD_TEXT) && (entry_index[10:4] == 7'd0);
  assign font_we   = in_xfer && (cmd == vmpe_pkg::CMD_FONT) &&
                     (font_widx < FCW'(FONT_DEPTH));

  // Colour table entries read as zero until written
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (color_we) begin
      cvalid[entry_index[7:0]] <= 1'b1;
    end
  end

  // Glyph row address; character zero and codes past the font are blank
  assign blank      = (source_byte == 8'd0) || ({1'b0, source_byte} >= 9'(GLYPH_COUNT));
  assign font_raddr = FCW'(source_byte) * FCW'(GLYPH_ROWS) + FCW'(glyph_line);

  vmpe_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_widx[FONT_AW-1:0]),
    .wdata (font_row_bits),
    .re    (pix_load),
    .raddr (font_raddr[FONT_AW-1:0]),
    .rdata (font_rdata)
  );

  vmpe_ram #(.WIDTH(16), .DEPTH(vmpe_pkg::COLOR_DEPTH)) u_color (
    .clk   (clk),
    .we    (color_we),
    .waddr (entry_index[7:0]),
    .wdata (vmpe_pkg::to_rgb565(color_rgb888)),
    .re    (issue && !req.text),
    .raddr (req.color_idx),
    .rdata (color_rdata)
  );

  vmpe_ram #(.WIDTH(16), .DEPTH(vmpe_pkg::TEXT_DEPTH)) u_text (
    .clk   (clk),
    .we    (text_we),
    .waddr (entry_index[3:0]),
    .wdata (text_color_rgb565),
    .re    (issue && req.text),
    .raddr (req.text_idx),
    .rdata (text_rdata)
  );

  vmpe_expander u_expander (
    .clk      (clk),
    .rst      (rst),
    .load     (pix_load),
    .mode     (display_mode),
    .fg       (foreground_color),
    .zfill    (zero_fill_lowres),
    .blank    (blank),
    .src      (source_byte),
    .attr     (attr_byte),
    .font_row (font_rdata),
    .grant    (issue),
    .req      (req)
  );

  // Read stage: track the pixel whose table read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_text   <= req.text;
      rd_cvalid <= cvalid[req.color_idx];
      rd_last   <= req.last;
    end
  end

  always_comb begin
    rd_pix.last = rd_last;
    if (rd_text) begin
      rd_pix.rgb = text_rdata;
    end else begin
      rd_pix.rgb = rd_cvalid ? color_rdata : 16'd0;
    end
  end

  vmpe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_data (rd_pix),
    .pop       (pop),
    .not_empty (out_valid),
    .count     (buf_count),
    .head      (head)
  );

  assign pixel_rgb565 = head.rgb;
  assign last         = head.last;

  // Reads in flight plus queued results never exceed the queue depth
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rd_valid} + {1'b0, buf_count}) <= 3'd2)
    else $error("result queue overrun");

  // Table writes only while no pixel read is pending
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cmd != vmpe_pkg::CMD_PIXEL) |-> !req.valid)
    else $error("table write overlaps pixel reads");

  // A new pixel item loads only when the previous one issues its last read
  assert property (@(posedge clk) disable iff (rst)
    (pix_load && req.valid) |-> (issue && req.last))
    else $error("expander item overwritten");

endmodule
